>>> rtl/core/md5_pkg.sv
package md5_pkg;

   typedef logic [3:0][31:0] word4_type;

   localparam word4_type INIT_WORDS = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] PAD_LEN_POS   = 6'd56;
   localparam logic [5:0] BLOCK_LAST    = 6'd63;
   localparam logic [5:0] ROUND_LAST    = 6'd63;
   localparam logic [2:0] LEN_BYTE_LAST = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
   } round_ctrl_type;

   typedef struct packed {
      logic last;
   } round_stat_type;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] SHIFT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word index used by a round
   function automatic logic [3:0] word_index(input logic [5:0] i);
      logic [3:0] lo;
      logic [3:0] g;
      lo = i[3:0];
      case (i[5:4])
         2'd0: g = lo;
         2'd1: g = 4'((lo << 2) + lo + 4'd1);
         2'd2: g = 4'((lo << 1) + lo + 4'd5);
         2'd3: g = 4'((lo << 3) - lo);
         default: g = lo;
      endcase
      return g;
   endfunction

endpackage

>>> rtl/core/md5_if.sv
interface md5_req_if;
   import md5_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last_of_message;

   modport source (output valid, output data_byte, output has_byte, output last_of_message,
                   input ready);
   modport sink (input valid, input data_byte, input has_byte, input last_of_message,
                 output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_low;
   logic [63:0] digest_high;

   modport source (output valid, output digest_low, output digest_high, input ready);
   modport sink (input valid, input digest_low, input digest_high, output ready);
endinterface

>>> rtl/core/md5_message_digest_unit.sv
// MD5 digest engine, one message byte per request.
//
// req_if carries data_byte, has_byte and last_of_message under valid/ready.
// A request with has_byte set appends its byte; one with last_of_message set
// closes the message after that byte: padding (0x80, zeros to offset 56, the
// 64-bit little-endian bit length) runs internally and the digest comes out
// on rsp_if as digest_low (bytes 0..7) and digest_high (bytes 8..15).
// A request with neither flag changes nothing.
//
// The byte that fills a 64-byte block starts its compression: one MD5 round
// per cycle on the shared round unit, loaded on the edge that writes the last
// byte, then a fold step. A closing request is followed by the pad bytes (9
// to 72), a step at offset 56 with no write, the compression of each block
// that fills and an emit step. req_if.ready is low while any of this is in
// progress.
//
// The digest sits in an output register; the next message can be taken while
// it waits. If the receiver still holds off when the next digest is done, the
// engine waits in the emit step. Reset (synchronous) loads the standard initial
// chaining value and clears the byte count, length and result valid.
module md5_message_digest_unit
   import md5_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   md5_req_if.sink   req_if,
   md5_rsp_if.source rsp_if
);

   state_type      state_ff, state_in;
   state_type      ret_ff, ret_in;
   state_type      after_put;
   logic [5:0]     pos_ff;
   logic [60:0]    len_ff;
   logic [2:0]     len_idx_ff;
   word4_type      cv_ff;
   logic           rsp_valid_ff;
   logic [63:0]    dig_lo_ff, dig_hi_ff;
   logic [3:0][7:0] blk_ff [16];

   logic           accept;
   logic           put_en;
   logic [7:0]     put_val;
   logic           fill;
   logic           fold;
   logic           emit_go;
   logic [63:0]    bit_len;
   round_ctrl_type rctrl;
   round_stat_type rstat;
   word4_type      work;
   logic [3:0]     msg_index;

   assign accept  = req_if.valid && req_if.ready;
   assign bit_len = {len_ff, 3'b000};

   md5_round_unit u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (rctrl),
      .init_words (cv_ff),
      .msg_word   (blk_ff[msg_index]),
      .msg_index  (msg_index),
      .words      (work),
      .stat       (rstat)
   );

   // Control outputs: which byte goes into the block, where to go after it.
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      put_en       = 1'b0;
      put_val      = '0;
      after_put    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               put_en    = req_if.has_byte;
               put_val   = req_if.data_byte;
               after_put = req_if.last_of_message ? ST_PAD_MARK : ST_IDLE;
            end
         end
         ST_PAD_MARK: begin
            put_en    = 1'b1;
            put_val   = PAD_MARK_BYTE;
            after_put = ST_PAD_ZERO;
         end
         ST_PAD_ZERO: begin
            // hold zeros until the length field offset
            if (pos_ff == PAD_LEN_POS) begin
               after_put = ST_PAD_LEN;
            end else begin
               put_en    = 1'b1;
               after_put = ST_PAD_ZERO;
            end
         end
         ST_PAD_LEN: begin
            put_en    = 1'b1;
            put_val   = bit_len[{len_idx_ff, 3'b000} +: 8];
            after_put = (len_idx_ff == LEN_BYTE_LAST) ? ST_EMIT : ST_PAD_LEN;
         end
         default: begin
         end
      endcase
      fill       = put_en && (pos_ff == BLOCK_LAST);
      rctrl.start = fill;
      rctrl.step  = (state_ff == ST_ROUND);
      fold        = (state_ff == ST_FOLD);
      emit_go     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_if.ready);
   end

   // Next state: a full block detours through the round loop, then resumes.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE, ST_PAD_MARK, ST_PAD_ZERO, ST_PAD_LEN: begin
            if (fill) begin
               state_in = ST_ROUND;
               ret_in   = after_put;
            end else begin
               state_in = after_put;
            end
         end
         ST_ROUND: begin
            if (rstat.last) state_in = ST_FOLD;
         end
         ST_FOLD: state_in = ret_ff;
         ST_EMIT: begin
            if (emit_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Block buffer: byte lanes, little-endian within each word.
   always_ff @(posedge clock) begin
      if (put_en) begin
         blk_ff[pos_ff[5:2]][pos_ff[1:0]] <= put_val;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         dig_lo_ff <= {cv_ff[1], cv_ff[0]};
         dig_hi_ff <= {cv_ff[3], cv_ff[2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         pos_ff       <= '0;
         len_ff       <= '0;
         len_idx_ff   <= '0;
         cv_ff        <= INIT_WORDS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         // position wraps to zero when the block fills
         if (put_en) pos_ff <= pos_ff + 6'd1;
         if (state_ff == ST_PAD_LEN) len_idx_ff <= len_idx_ff + 3'd1;
         if (accept && req_if.has_byte) begin
            len_ff <= len_ff + 61'd1;
         end else if (emit_go) begin
            len_ff <= '0;
         end
         if (fold) begin
            for (int k = 0; k < 4; k++) begin
               cv_ff[k] <= cv_ff[k] + work[k];
            end
         end else if (emit_go) begin
            cv_ff <= INIT_WORDS;
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.digest_low  = dig_lo_ff;
   assign rsp_if.digest_high = dig_hi_ff;

endmodule

>>> rtl/core/md5_round_unit.sv
module md5_round_unit
   import md5_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  round_ctrl_type ctrl,
   input  word4_type      init_words,
   input  logic [31:0]    msg_word,
   output logic [3:0]     msg_index,
   output word4_type      words,
   output round_stat_type stat
);

   word4_type   work_ff, work_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] f_val;
   logic [31:0] t_val;
   logic [63:0] rot_wide;
   logic [31:0] a_w, b_w, c_w, d_w;

   assign a_w = work_ff[0];
   assign b_w = work_ff[1];
   assign c_w = work_ff[2];
   assign d_w = work_ff[3];

   assign msg_index = word_index(round_ff);

   always_comb begin
      case (round_ff[5:4])
         2'd0: f_val = (b_w & c_w) | (~b_w & d_w);
         2'd1: f_val = (d_w & b_w) | (~d_w & c_w);
         2'd2: f_val = b_w ^ c_w ^ d_w;
         2'd3: f_val = c_w ^ (b_w | ~d_w);
         default: f_val = '0;
      endcase
   end

   // rotate left: upper half of the doubled word shifted
   always_comb begin
      t_val    = a_w + f_val + ROUND_CONST[round_ff] + msg_word;
      rot_wide = {t_val, t_val} << SHIFT_AMOUNT[{round_ff[5:4], round_ff[1:0]}];
   end

   always_comb begin
      work_in  = work_ff;
      round_in = round_ff;
      if (ctrl.start) begin
         work_in  = init_words;
         round_in = '0;
      end else if (ctrl.step) begin
         work_in[0] = d_w;
         work_in[3] = c_w;
         work_in[2] = b_w;
         work_in[1] = b_w + rot_wide[63:32];
         round_in   = round_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff  <= '0;
         round_ff <= '0;
      end else begin
         work_ff  <= work_in;
         round_ff <= round_in;
      end
   end

   assign words     = work_ff;
   assign stat.last = (round_ff == ROUND_LAST);

endmodule

>>> test/md5_digest_check_pkg.sv
package md5_digest_check_pkg;

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] high;
   } digest_pair_type;

   localparam logic [31:0] SINE_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int unsigned ROTATE_BY [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   class md5_digest_predictor;
      logic [31:0]     chain [4];
      logic [7:0]      block_bytes [64];
      int unsigned     fill;
      logic [60:0]     length_bytes;
      digest_pair_type expected_digests [$];
      int unsigned     mismatches;

      function new();
         mismatches = 0;
         foreach (block_bytes[i]) block_bytes[i] = 8'h00;
         start_message();
      endfunction

      function void start_message();
         chain[0]     = 32'h67452301;
         chain[1]     = 32'hefcdab89;
         chain[2]     = 32'h98badcfe;
         chain[3]     = 32'h10325476;
         fill         = 0;
         length_bytes = '0;
      endfunction

      function void compress_block();
         logic [31:0] a, b, c, d, f, t, m, rotated;
         int unsigned g, s;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         for (int unsigned i = 0; i < 64; i++) begin
            case (i / 16)
               0: begin
                  f = (b & c) | (~b & d);
                  g = i;
               end
               1: begin
                  f = (d & b) | (~d & c);
                  g = (5 * i + 1) % 16;
               end
               2: begin
                  f = b ^ c ^ d;
                  g = (3 * i + 5) % 16;
               end
               default: begin
                  f = c ^ (b | ~d);
                  g = (7 * i) % 16;
               end
            endcase
            m = {block_bytes[4*g+3], block_bytes[4*g+2], block_bytes[4*g+1], block_bytes[4*g]};
            t = a + f + SINE_TABLE[i] + m;
            s = ROTATE_BY[(i / 16) * 4 + i % 4];
            rotated = (t << s) | (t >> (32 - s));
            a = d;
            d = c;
            c = b;
            b = b + rotated;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
      endfunction

      function void put_byte(input logic [7:0] value);
         block_bytes[fill] = value;
         fill++;
         if (fill == 64) begin
            compress_block();
            fill = 0;
         end
      endfunction

      // fold one accepted request into the running message
      function void take_request(input logic [7:0] data, input logic has, input logic last);
         logic [63:0] bit_length;
         if (has) begin
            put_byte(data);
            length_bytes = length_bytes + 61'd1;
         end
         if (!last) return;
         bit_length = {length_bytes, 3'b000};
         put_byte(8'h80);
         while (fill != 56) put_byte(8'h00);
         for (int k = 0; k < 8; k++) put_byte(bit_length[8*k +: 8]);
         expected_digests.push_back('{low: {chain[1], chain[0]}, high: {chain[3], chain[2]}});
         start_message();
      endfunction

      function void check_digest(input logic [63:0] low, input logic [63:0] high);
         digest_pair_type want;
         if (expected_digests.size() == 0) begin
            $error("unexpected digest: digest_low %h digest_high %h", low, high);
            mismatches++;
            return;
         end
         want = expected_digests.pop_front();
         if (low !== want.low) begin
            $error("digest_low mismatch: expected %h, got %h", want.low, low);
            mismatches++;
         end
         if (high !== want.high) begin
            $error("digest_high mismatch: expected %h, got %h", want.high, high);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_digests.size();
      endfunction
   endclass

endpackage

>>> test/md5_message_digest_unit_tb.sv
module md5_message_digest_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import md5_digest_check_pkg::*;

   // run length and pacing
   localparam int unsigned CYCLE_LIMIT      = 2000000;
   localparam int unsigned RANDOM_REQUESTS  = 1150;
   localparam int unsigned CALM_FROM        = 950;
   localparam int unsigned LONG_HOLD_CYCLES = 800;
   // settle time after the final drain, for stray digests to show up
   localparam int unsigned SETTLE_CYCLES    = 300;

   // message lengths around the padding and block boundaries
   localparam int unsigned EDGE_LENGTHS [12] = '{
      0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 128
   };

   logic clock;
   logic reset;

   md5_req_if req_if ();
   md5_rsp_if rsp_if ();

   md5_digest_predictor digests = new();

   // pacing knobs, written only by the stimulus process
   bit          sender_idles    = 1'b1;
   bit          receiver_stalls = 1'b1;
   int unsigned hold_requests   = 0;

   int unsigned counted_requests = 0;
   int unsigned closed_messages  = 0;

   md5_message_digest_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one request and hold it until the block takes it. Note it in the
   // predictor at the accepting edge, then maybe drop valid for a short burst.
   task automatic push_request(input logic [7:0] data, input logic has, input logic last);
      req_if.valid           <= 1'b1;
      req_if.data_byte       <= data;
      req_if.has_byte        <= has;
      req_if.last_of_message <= last;
      do @(posedge clock); while (!req_if.ready);
      digests.take_request(data, has, last);
      if (has || last) counted_requests++;
      if (last) closed_messages++;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Send a whole message of random bytes. Close it either on the final byte
   // or with a separate request that carries no byte; sprinkle in requests
   // with neither flag, which the block must ignore.
   task automatic send_message(input int unsigned len);
      logic end_on_byte;
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned k = 0; k < len; k++) begin
         if ($urandom_range(0, 15) == 0) push_request(8'($urandom), 1'b0, 1'b0);
         push_request(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
      end
      if (!end_on_byte) push_request(8'($urandom), 1'b0, 1'b1);
   endtask

   // drop valid and hold until every expected digest is back
   task automatic wait_for_digests();
      req_if.valid <= 1'b0;
      while (digests.pending() != 0) @(posedge clock);
   endtask

   // Receiver: check every digest taken, then pick ready for the next edge.
   // A long hold-off is counted here, so the sender keeps pushing meanwhile.
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned holds_served;
      stall_left   = 0;
      hold_left    = 0;
      holds_served = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            digests.check_digest(rsp_if.digest_low, rsp_if.digest_high);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog: give up if the run hangs.
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int unsigned len;
      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.data_byte       <= 8'h00;
      req_if.has_byte        <= 1'b0;
      req_if.last_of_message <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message straight out of reset
      push_request(8'h00, 1'b0, 1'b1);
      // ignored request carrying a busy data byte
      push_request(8'hA5, 1'b0, 1'b0);
      // "abc", closed on its last byte
      push_request(8'h61, 1'b1, 1'b0);
      push_request(8'h62, 1'b1, 1'b0);
      push_request(8'h63, 1'b1, 1'b1);
      // single all-ones byte that also closes
      push_request(8'hFF, 1'b1, 1'b1);
      // single zero byte, an ignored request, then a close without a byte
      push_request(8'h00, 1'b1, 1'b0);
      push_request(8'hFF, 1'b0, 1'b0);
      push_request(8'hFF, 1'b0, 1'b1);
      // back-to-back empty messages, data byte must not leak in
      push_request(8'h00, 1'b0, 1'b1);
      push_request(8'h5A, 1'b0, 1'b1);
      // alternating bit patterns
      push_request(8'h55, 1'b1, 1'b0);
      push_request(8'hAA, 1'b1, 1'b0);
      push_request(8'h0F, 1'b1, 1'b1);

      // hold the sender until every digest so far is back
      wait_for_digests();

      // Stall the receiver for a long stretch and keep closing short
      // messages: the output register fills, the engine parks in emit and
      // the request side must back up.
      hold_requests++;
      repeat (6) send_message($urandom_range(0, 3));

      // Random messages: mostly short, some right on the padding edges,
      // some spanning two or three blocks. Drop all idling near the end.
      while (counted_requests < RANDOM_REQUESTS) begin
         if (counted_requests >= CALM_FROM) begin
            sender_idles    = 1'b0;
            receiver_stalls = 1'b0;
         end else begin
            sender_idles = ($urandom_range(0, 2) != 0);
         end
         case ($urandom_range(0, 3))
            0, 1:    len = $urandom_range(0, 8);
            2:       len = EDGE_LENGTHS[$urandom_range(0, 11)];
            default: len = $urandom_range(0, 130);
         endcase
         send_message(len);
      end

      // drain, then give stray digests time to show up
      wait_for_digests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (digests.mismatches == 0 && digests.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
